// File: sv/rsi_pkg.sv
// Shared types and widths for the ray and sphere intersection pipeline.
// Used by every module of the block; has no dependencies of its own.

package rsi_pkg;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 12;

	// Exact intermediate widths, following from the coordinate and fraction widths; T_W is fixed.
	localparam int OC_W   = COORD_BITS + 1;
	localparam int DD_W   = 2 * COORD_BITS - 1;
	localparam int OO_W   = 2 * COORD_BITS;
	localparam int A_W    = 2 * COORD_BITS;
	localparam int B_W    = 2 * COORD_BITS + 1;
	localparam int BS_W   = B_W + 2;
	localparam int S_W    = 2 * COORD_BITS + 2;
	localparam int R2_W   = 2 * (COORD_BITS - 1);
	localparam int D_W    = 4 * COORD_BITS + 2;
	localparam int P_W    = D_W + 2;
	localparam int X_W    = D_W + 2 * FRAC_BITS;
	localparam int SQ_STEPS = X_W / 2;
	localparam int ROOT_W = SQ_STEPS;
	localparam int SQREM_W = ROOT_W + 2;
	localparam int NUM_W  = ROOT_W + 1;
	localparam int T_W    = 32;
	localparam int DIV_STEPS = T_W;

	// Split point for the wide products.
	localparam int LO    = COORD_BITS;
	localparam int BH_W  = B_W - LO;
	localparam int AH_W  = A_W - LO;
	localparam int RH_W  = R2_W - LO;
	localparam int SH_W  = S_W - LO;

	localparam int FRONT_STAGES = 8;

	localparam logic [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
	localparam logic [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] origin_x;
		logic signed [COORD_BITS-1:0] origin_y;
		logic signed [COORD_BITS-1:0] origin_z;
		logic signed [COORD_BITS-1:0] dir_x;
		logic signed [COORD_BITS-1:0] dir_y;
		logic signed [COORD_BITS-1:0] dir_z;
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic signed [COORD_BITS-1:0] center_z;
		logic [COORD_BITS-2:0]        radius;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic signed [T_W-1:0] t_near;
		logic                  saturated;
	} res_t;

	typedef struct packed {
		logic [B_W-1:0] bmag;
		logic           bneg;
		logic [A_W-1:0] a;
		logic           hit;
	} side_t;

	typedef struct packed {
		logic [X_W-1:0]     x;
		logic [ROOT_W-1:0]  root;
		logic [SQREM_W-1:0] rem;
		side_t              side;
	} sq_t;

	typedef struct packed {
		logic [A_W-1:0]       rem;
		logic [DIV_STEPS-1:0] low;
		logic [DIV_STEPS-1:0] q;
		logic [A_W-1:0]       a;
		logic                 neg;
		logic                 big;
		logic                 hit;
	} dv_t;

endpackage

// File: sv/rsi_front.sv
// Front pipeline: forms A, b, |oc|^2 and r^2, the discriminant and the scaled radicand.
// Depends on rsi_pkg.

module rsi_front import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic req_valid,
	input  req_t req,
	output logic dn_vld,
	output sq_t  dn
);

	logic [FRONT_STAGES-1:0] vld_q;

	logic signed [OC_W-1:0]       oc_s1 [3];
	logic signed [COORD_BITS-1:0] d_s1 [3];
	logic [COORD_BITS-2:0]        r_s1;

	logic signed [B_W-1:0] bp_s2 [3];
	logic [DD_W-1:0]       dd_s2 [3];
	logic [OO_W-1:0]       oo_s2 [3];
	logic [R2_W-1:0]       r2_s2;

	logic [A_W-1:0]         a_s3;
	logic signed [BS_W-1:0] b_s3;
	logic [S_W-1:0]         s_s3;
	logic [R2_W-1:0]        r2_s3;

	logic [B_W-1:0]  bmag_s4;
	logic            bneg_s4;
	logic [A_W-1:0]  a_s4;
	logic [S_W-1:0]  s_s4;
	logic [R2_W-1:0] r2_s4;

	logic [2*BH_W-1:0]   bb_hh_s5;
	logic [BH_W+LO-1:0]  bb_hl_s5;
	logic [2*LO-1:0]     bb_ll_s5;
	logic [AH_W+RH_W-1:0] ar_hh_s5;
	logic [AH_W+LO-1:0]  ar_hl_s5;
	logic [LO+RH_W-1:0]  ar_lh_s5;
	logic [2*LO-1:0]     ar_ll_s5;
	logic [AH_W+SH_W-1:0] as_hh_s5;
	logic [AH_W+LO-1:0]  as_hl_s5;
	logic [LO+SH_W-1:0]  as_lh_s5;
	logic [2*LO-1:0]     as_ll_s5;
	logic [B_W-1:0]      bmag_s5;
	logic                bneg_s5;
	logic [A_W-1:0]      a_s5;

	logic [P_W-1:0] bb_s6, ar_s6, as_s6;
	logic [B_W-1:0] bmag_s6;
	logic           bneg_s6;
	logic [A_W-1:0] a_s6;

	logic [P_W-1:0] p_s7, n_s7;
	logic [B_W-1:0] bmag_s7;
	logic           bneg_s7;
	logic [A_W-1:0] a_s7;

	logic [P_W-1:0] diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[FRONT_STAGES-2:0], req_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oc_s1[0] <= OC_W'(req.origin_x) - OC_W'(req.center_x);
			oc_s1[1] <= OC_W'(req.origin_y) - OC_W'(req.center_y);
			oc_s1[2] <= OC_W'(req.origin_z) - OC_W'(req.center_z);
			d_s1[0]  <= req.dir_x;
			d_s1[1]  <= req.dir_y;
			d_s1[2]  <= req.dir_z;
			r_s1     <= req.radius;

			for (int k = 0; k < 3; k++) begin
				bp_s2[k] <= B_W'(d_s1[k]) * B_W'(oc_s1[k]);
				dd_s2[k] <= DD_W'(A_W'(d_s1[k]) * A_W'(d_s1[k]));
				oo_s2[k] <= OO_W'(B_W'(oc_s1[k]) * B_W'(oc_s1[k]));
			end
			r2_s2 <= R2_W'(r_s1) * R2_W'(r_s1);

			a_s3  <= A_W'(dd_s2[0]) + A_W'(dd_s2[1]) + A_W'(dd_s2[2]);
			b_s3  <= BS_W'(bp_s2[0]) + BS_W'(bp_s2[1]) + BS_W'(bp_s2[2]);
			s_s3  <= S_W'(oo_s2[0]) + S_W'(oo_s2[1]) + S_W'(oo_s2[2]);
			r2_s3 <= r2_s2;

			bmag_s4 <= b_s3[BS_W-1] ? B_W'(-b_s3) : B_W'(b_s3);
			bneg_s4 <= b_s3[BS_W-1];
			a_s4    <= a_s3;
			s_s4    <= s_s3;
			r2_s4   <= r2_s3;

			// Partial products of b^2, A r^2 and A S, split at LO bits.
			bb_hh_s5 <= bmag_s4[B_W-1:LO] * bmag_s4[B_W-1:LO];
			bb_hl_s5 <= bmag_s4[B_W-1:LO] * bmag_s4[LO-1:0];
			bb_ll_s5 <= bmag_s4[LO-1:0] * bmag_s4[LO-1:0];
			ar_hh_s5 <= a_s4[A_W-1:LO] * r2_s4[R2_W-1:LO];
			ar_hl_s5 <= a_s4[A_W-1:LO] * r2_s4[LO-1:0];
			ar_lh_s5 <= a_s4[LO-1:0] * r2_s4[R2_W-1:LO];
			ar_ll_s5 <= a_s4[LO-1:0] * r2_s4[LO-1:0];
			as_hh_s5 <= a_s4[A_W-1:LO] * s_s4[S_W-1:LO];
			as_hl_s5 <= a_s4[A_W-1:LO] * s_s4[LO-1:0];
			as_lh_s5 <= a_s4[LO-1:0] * s_s4[S_W-1:LO];
			as_ll_s5 <= a_s4[LO-1:0] * s_s4[LO-1:0];
			bmag_s5  <= bmag_s4;
			bneg_s5  <= bneg_s4;
			a_s5     <= a_s4;

			// The cross term of b^2 appears twice, hence one more bit of shift.
			bb_s6 <= (P_W'(bb_hh_s5) << (2*LO)) + (P_W'(bb_hl_s5) << (LO+1))
				+ P_W'(bb_ll_s5);
			ar_s6 <= (P_W'(ar_hh_s5) << (2*LO)) + (P_W'(ar_hl_s5) << LO)
				+ (P_W'(ar_lh_s5) << LO) + P_W'(ar_ll_s5);
			as_s6 <= (P_W'(as_hh_s5) << (2*LO)) + (P_W'(as_hl_s5) << LO)
				+ (P_W'(as_lh_s5) << LO) + P_W'(as_ll_s5);
			bmag_s6 <= bmag_s5;
			bneg_s6 <= bneg_s5;
			a_s6    <= a_s5;

			p_s7    <= bb_s6 + ar_s6;
			n_s7    <= as_s6;
			bmag_s7 <= bmag_s6;
			bneg_s7 <= bneg_s6;
			a_s7    <= a_s6;

			dn.x         <= X_W'(diff[D_W-1:0]) << (2*FRAC_BITS);
			dn.root      <= '0;
			dn.rem       <= '0;
			dn.side.bmag <= bmag_s7;
			dn.side.bneg <= bneg_s7;
			dn.side.a    <= a_s7;
			dn.side.hit  <= (a_s7 != '0) && (p_s7 >= n_s7);
		end
	end

	assign diff   = p_s7 - n_s7;
	assign dn_vld = vld_q[FRONT_STAGES-1];

endmodule

// File: sv/rsi_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per cell.
// Depends on rsi_pkg.

module rsi_sqrt_cell import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic up_vld,
	input  sq_t  up,
	output logic dn_vld,
	output sq_t  dn
);

	logic [SQREM_W+1:0] cur;
	logic [SQREM_W+1:0] trial;
	logic               take;

	// Bring down the next two radicand bits and try root*4+1.
	assign cur   = {up.rem, up.x[X_W-1:X_W-2]};
	assign trial = (SQREM_W+2)'({up.root, 2'b01});
	assign take  = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_vld <= 1'b0;
		end else if (en) begin
			dn_vld <= up_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn.x    <= up.x << 2;
			dn.root <= {up.root[ROOT_W-2:0], take};
			dn.rem  <= take ? SQREM_W'(cur - trial) : cur[SQREM_W-1:0];
			dn.side <= up.side;
		end
	end

endmodule

// File: sv/rsi_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit per cell.
// Depends on rsi_pkg.

module rsi_div_cell import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic up_vld,
	input  dv_t  up,
	output logic dn_vld,
	output dv_t  dn
);

	logic [A_W:0] cur;
	logic         take;

	assign cur  = {up.rem, up.low[DIV_STEPS-1]};
	assign take = cur >= {1'b0, up.a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_vld <= 1'b0;
		end else if (en) begin
			dn_vld <= up_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn.rem  <= take ? A_W'(cur - {1'b0, up.a}) : cur[A_W-1:0];
			dn.low  <= up.low << 1;
			dn.q    <= {up.q[DIV_STEPS-2:0], take};
			dn.a    <= up.a;
			dn.neg  <= up.neg;
			dn.big  <= up.big;
			dn.hit  <= up.hit;
		end
	end

endmodule

// File: sv/ray_sphere_intersection.sv
// Top level of the ray and sphere intersection pipeline.
// Depends on rsi_pkg, rsi_front, rsi_sqrt_cell and rsi_div_cell.
//
//  channel | signals                  | carries
//  --------+--------------------------+-------------------------------------
//  req     | req_valid, req_ready, req | one ray and sphere pair (req_t)
//  res     | res_valid, res_ready, res | hit, nearest t, saturation (res_t)
//
// One request enters every cycle unless halted; it passes 8 front stages,
// 61 square-root cells, a numerator stage, 32 divider cells and the result
// register. Reset clears only the valid bits; no state survives a request.
// The chain halts only while the result register is held and the last
// divider cell also holds a request; all stages, empty ones too, stop then.

module ray_sphere_intersection import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	logic en;

	sq_t               sq_bus [SQ_STEPS+1];
	logic [SQ_STEPS:0] sq_vld;

	dv_t                dv_bus [DIV_STEPS+1];
	logic [DIV_STEPS:0] dv_vld;

	logic [NUM_W-1:0] lhs, root_w, num;
	logic             num_neg;

	logic             num_vld_q;
	dv_t              num_q;

	logic             res_valid_q;
	res_t             res_q;
	res_t             res_next;

	assign en        = !(dv_vld[DIV_STEPS] && res_valid_q && !res_ready);
	assign req_ready = en;

	rsi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.req_valid (req_valid),
		.req       (req),
		.dn_vld    (sq_vld[0]),
		.dn        (sq_bus[0])
	);

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		rsi_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.up_vld (sq_vld[i]),
			.up     (sq_bus[i]),
			.dn_vld (sq_vld[i+1]),
			.dn     (sq_bus[i+1])
		);
	end

	// Numerator (-b) * 2^FRAC_BITS - root, as magnitude and sign.
	always_comb begin
		lhs     = NUM_W'({sq_bus[SQ_STEPS].side.bmag, {FRAC_BITS{1'b0}}});
		root_w  = NUM_W'(sq_bus[SQ_STEPS].root);
		num     = lhs + root_w;
		num_neg = 1'b1;
		if (sq_bus[SQ_STEPS].side.bneg) begin
			if (lhs >= root_w) begin
				num     = lhs - root_w;
				num_neg = 1'b0;
			end else begin
				num     = root_w - lhs;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vld_q <= 1'b0;
		end else if (en) begin
			num_vld_q <= sq_vld[SQ_STEPS];
		end
	end

	// A quotient that needs more than DIV_STEPS bits is flagged here and
	// saturates at the end of the divider.
	always_ff @(posedge clk) begin
		if (en) begin
			num_q.rem <= A_W'(num[NUM_W-1:DIV_STEPS]);
			num_q.low <= num[DIV_STEPS-1:0];
			num_q.q   <= '0;
			num_q.a   <= sq_bus[SQ_STEPS].side.a;
			num_q.neg <= num_neg;
			num_q.big <= A_W'(num[NUM_W-1:DIV_STEPS]) >= sq_bus[SQ_STEPS].side.a;
			num_q.hit <= sq_bus[SQ_STEPS].side.hit;
		end
	end

	assign dv_vld[0] = num_vld_q;
	assign dv_bus[0] = num_q;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		rsi_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.up_vld (dv_vld[j]),
			.up     (dv_bus[j]),
			.dn_vld (dv_vld[j+1]),
			.dn     (dv_bus[j+1])
		);
	end

	always_comb begin
		res_next = '0;
		if (dv_bus[DIV_STEPS].hit) begin
			res_next.hit = 1'b1;
			if (!dv_bus[DIV_STEPS].neg) begin
				if (dv_bus[DIV_STEPS].big || dv_bus[DIV_STEPS].q > T_MAX) begin
					res_next.t_near    = T_MAX;
					res_next.saturated = 1'b1;
				end else begin
					res_next.t_near = dv_bus[DIV_STEPS].q;
				end
			end else begin
				if (dv_bus[DIV_STEPS].big || dv_bus[DIV_STEPS].q > T_MIN) begin
					res_next.t_near    = T_MIN;
					res_next.saturated = 1'b1;
				end else begin
					res_next.t_near = -dv_bus[DIV_STEPS].q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res_ready) begin
			res_valid_q <= dv_vld[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || res_ready) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (res_valid && !res_ready && dv_vld[DIV_STEPS]))
		else $error("request side stalled without a blocked result");

	a_miss_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.hit) |-> (res.t_near == '0 && !res.saturated))
		else $error("miss result carries a nonzero root or saturation");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.saturated) |-> (res.t_near == T_MAX || res.t_near == T_MIN))
		else $error("saturated root is not at a range limit");

	a_held_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("held result changed or vanished");
`endif

endmodule
